@@ hdl/qs_pkg.sv @@
// ----------------------------------------------------------------------------
// qs_pkg
// Shared constants, tables and types of the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qs_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_STEPS = 30;

    // normalizer: 10 front stages, root cells, divide setup, divide cells, output
    localparam int NORM_LAT  = 10 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    // middle section: root cells, vectoring cells, two angle stages, rotation cells
    localparam int MID_LAT   = SQRT_STEPS + CORDIC_STEPS + 2 + CORDIC_STEPS;
    // two normalizers, dot/cosine stages, middle section, blend stages
    localparam int TOTAL_LAT = 2 * NORM_LAT + 6 + MID_LAT + 2;

    localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [16:0]        BLEND_ONE   = 17'd65536;
    localparam logic [13:0]        COS_SCALE   = 14'd10000;
    localparam logic [44:0]        COS_LIMIT   = 45'd10732049530880;

    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
        30'd32,        30'd16,        30'd8,         30'd4,         30'd2
    };

    typedef enum logic {
        CORDIC_VECTOR = 1'b0,
        CORDIC_ROTATE = 1'b1
    } qs_cordic_mode_t;

    // operands that travel beside the angle math
    typedef struct packed {
        logic [3:0][31:0] ua;
        logic [3:0][31:0] ub;
        logic [16:0]      t;
        logic             lin;
        logic [30:0]      c30;
    } qs_side_t;

    // scaled magnitudes and signs that travel beside the root cells
    typedef struct packed {
        logic [3:0][30:0] mag;
        logic [3:0]       sgn;
        logic             zero;
    } qs_nside_t;

endpackage

@@ hdl/qs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qs_sqrt_cell
// One step of the restoring integer square root: one trial bit per cell.
// ----------------------------------------------------------------------------
module qs_sqrt_cell (
    input  logic        aclk,
    input  logic        adv,
    input  logic [4:0]  idx,
    input  logic [63:0] rad_in,
    input  logic [63:0] root_in,
    output logic [63:0] rad_out,
    output logic [63:0] root_out
);

    logic [5:0]  sh;
    logic [63:0] bit_val;
    logic [63:0] trial;
    logic        fits;
    logic [63:0] rad_reg, rad_next;
    logic [63:0] root_reg, root_next;

    // trial subtract of root plus the current bit
    assign sh      = 6'd62 - {idx, 1'b0};
    assign bit_val = 64'd1 << sh;
    assign trial   = root_in + bit_val;
    assign fits    = (rad_in >= trial);

    always_comb begin
        rad_next  = fits ? (rad_in - trial) : rad_in;
        root_next = fits ? ((root_in >> 1) + bit_val) : (root_in >> 1);
    end

    // hand the partial result to the next cell
    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign root_out = root_reg;

endmodule

@@ hdl/qs_div_cell.sv @@
// ----------------------------------------------------------------------------
// qs_div_cell
// One step of restoring division: shift in a numerator bit, try the divisor.
// ----------------------------------------------------------------------------
module qs_div_cell (
    input  logic        aclk,
    input  logic        adv,
    input  logic [31:0] rem_in,
    input  logic [30:0] quo_in,
    input  logic [31:0] dvs_in,
    output logic [31:0] rem_out,
    output logic [30:0] quo_out,
    output logic [31:0] dvs_out
);

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] quo_reg, quo_next;
    logic [31:0] dvs_reg;

    // partial remainder stays below the divisor, so 33 bits cover the trial
    assign trial = {rem_in, quo_in[30]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = (trial >= {1'b0, dvs_in});

    always_comb begin
        rem_next = ge ? diff[31:0] : trial[31:0];
        quo_next = {quo_in[29:0], ge};
    end

    // advance remainder, quotient bits and divisor
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvs_reg <= dvs_in;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign dvs_out = dvs_reg;

endmodule

@@ hdl/qs_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// qs_cordic_cell
// One CORDIC micro-rotation, in vectoring or rotation mode.
// ----------------------------------------------------------------------------
module qs_cordic_cell (
    input  logic                    aclk,
    input  logic                    adv,
    input  qs_pkg::qs_cordic_mode_t mode,
    input  logic [4:0]              idx,
    input  logic signed [33:0]      x_in,
    input  logic signed [33:0]      y_in,
    input  logic signed [33:0]      z_in,
    output logic signed [33:0]      x_out,
    output logic signed [33:0]      y_out,
    output logic signed [33:0]      z_out
);

    logic signed [33:0] dx, dy, at;
    logic               pos;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;

    assign dx  = y_in >>> idx;
    assign dy  = x_in >>> idx;
    assign at  = $signed({4'd0, qs_pkg::ATAN_Q30[idx]});
    // vectoring steers on y, rotation steers on the residual angle
    assign pos = (mode == qs_pkg::CORDIC_VECTOR) ? !y_in[33] : !z_in[33];

    always_comb begin
        if (mode == qs_pkg::CORDIC_VECTOR) begin
            x_next = pos ? (x_in + dx) : (x_in - dx);
            y_next = pos ? (y_in - dy) : (y_in + dy);
            z_next = pos ? (z_in + at) : (z_in - at);
        end else begin
            x_next = pos ? (x_in - dx) : (x_in + dx);
            y_next = pos ? (y_in + dy) : (y_in - dy);
            z_next = pos ? (z_in - at) : (z_in + at);
        end
    end

    // pass the rotated vector on
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

@@ hdl/qs_norm.sv @@
// ----------------------------------------------------------------------------
// qs_norm
// Scales a four-component vector to unit length in Q30, pipelined: block
// scaling, sum of squares, root cell chain and a divider cell chain per lane.
// ----------------------------------------------------------------------------
module qs_norm (
    input  logic             aclk,
    input  logic             adv,
    input  logic [3:0][63:0] vec_in,
    output logic [3:0][31:0] unit_out
);

    // stage 1..7: magnitudes, maximum, leading one, scaling
    logic [3:0][63:0] mag1_reg, mag1_next;
    logic [3:0]       sgn1_reg;
    logic [1:0][63:0] mx2_reg, mx2_next;
    logic [3:0][63:0] mag2_reg;
    logic [3:0]       sgn2_reg;
    logic [63:0]      big3_reg, big3_next;
    logic [3:0][63:0] mag3_reg;
    logic [3:0]       sgn3_reg;
    logic [7:0]       nz4_reg, nz4_next;
    logic [7:0][2:0]  msb4_reg, msb4_next;
    logic [63:0]      big4_reg;
    logic [3:0][63:0] mag4_reg;
    logic [3:0]       sgn4_reg;
    logic [5:0]       pos5_reg, pos5_next;
    logic             zero5_reg;
    logic [63:0]      big5_reg;
    logic [3:0][63:0] mag5_reg;
    logic [3:0]       sgn5_reg;
    logic [5:0]       rsh, lsh;
    logic             right;
    logic [63:0]      big6_reg, big6_next;
    logic [3:0][63:0] mag6_reg, mag6_next;
    logic [3:0]       sgn6_reg;
    logic             zero6_reg;
    logic             over;
    qs_pkg::qs_nside_t side7_reg, side7_next;
    // stage 8..10: sum of squares
    logic [3:0][61:0] sq8_reg, sq8_next;
    qs_pkg::qs_nside_t side8_reg;
    logic [1:0][62:0] ps9_reg;
    qs_pkg::qs_nside_t side9_reg;
    logic [63:0]      tot10_reg;
    qs_pkg::qs_nside_t side10_reg;
    // root chain
    logic [63:0] rad_w  [0:qs_pkg::SQRT_STEPS];
    logic [63:0] root_w [0:qs_pkg::SQRT_STEPS];
    qs_pkg::qs_nside_t sq_side_reg [0:qs_pkg::SQRT_STEPS-1];
    // divider setup and chain
    logic [31:0]      dvs;
    logic [3:0][60:0] num;
    logic [31:0]      rem_w [4][0:qs_pkg::DIV_STEPS];
    logic [30:0]      quo_w [4][0:qs_pkg::DIV_STEPS];
    logic [31:0]      dvs_w [4][0:qs_pkg::DIV_STEPS];
    logic [3:0][31:0] remp_reg;
    logic [3:0][30:0] quop_reg;
    logic [31:0]      dvsp_reg;
    logic [4:0]       sidep_reg;
    logic [4:0]       dv_side_reg [0:qs_pkg::DIV_STEPS-1];
    // output
    logic [3:0][31:0] unit_reg, unit_next;
    logic [3:0][30:0] capq;
    logic [3:0]       out_sgn;
    logic             out_zero;

    // take magnitudes and signs
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag1_next[i] = vec_in[i][63] ? (64'd0 - vec_in[i]) : vec_in[i];
        end
    end

    // find the largest magnitude over two stages
    always_comb begin
        mx2_next[0] = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
        mx2_next[1] = (mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3];
        big3_next   = (mx2_reg[0] > mx2_reg[1]) ? mx2_reg[0] : mx2_reg[1];
    end

    // locate the leading one: per byte, then across bytes
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            nz4_next[b]  = |big3_reg[8*b +: 8];
            msb4_next[b] = 3'd0;
            for (int j = 0; j < 8; j++) begin
                if (big3_reg[8*b + j]) msb4_next[b] = 3'(j);
            end
        end
        pos5_next = 6'd0;
        for (int b = 0; b < 8; b++) begin
            if (nz4_reg[b]) pos5_next = {3'(b), msb4_reg[b]};
        end
    end

    // shift all magnitudes together so the largest lands near 2^30
    always_comb begin
        right = (pos5_reg >= 6'd30);
        rsh   = pos5_reg - 6'd30;
        lsh   = 6'd29 - pos5_reg;
        big6_next = right ? (big5_reg >> rsh) : (big5_reg << lsh);
        for (int i = 0; i < 4; i++) begin
            mag6_next[i] = right ? (mag5_reg[i] >> rsh) : (mag5_reg[i] << lsh);
        end
    end

    // drop one more bit when the largest still exceeds one
    always_comb begin
        over = (big6_reg > 64'(qs_pkg::ONE_Q30));
        for (int i = 0; i < 4; i++) begin
            side7_next.mag[i] = over ? mag6_reg[i][31:1] : mag6_reg[i][30:0];
        end
        side7_next.sgn  = sgn6_reg;
        side7_next.zero = zero6_reg;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sq8_next[i] = 62'(side7_reg.mag[i]) * 62'(side7_reg.mag[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag1_reg   <= mag1_next;
            for (int i = 0; i < 4; i++) sgn1_reg[i] <= vec_in[i][63];
            mx2_reg    <= mx2_next;
            mag2_reg   <= mag1_reg;
            sgn2_reg   <= sgn1_reg;
            big3_reg   <= big3_next;
            mag3_reg   <= mag2_reg;
            sgn3_reg   <= sgn2_reg;
            nz4_reg    <= nz4_next;
            msb4_reg   <= msb4_next;
            big4_reg   <= big3_reg;
            mag4_reg   <= mag3_reg;
            sgn4_reg   <= sgn3_reg;
            pos5_reg   <= pos5_next;
            zero5_reg  <= ~|nz4_reg;
            big5_reg   <= big4_reg;
            mag5_reg   <= mag4_reg;
            sgn5_reg   <= sgn4_reg;
            big6_reg   <= big6_next;
            mag6_reg   <= mag6_next;
            sgn6_reg   <= sgn5_reg;
            zero6_reg  <= zero5_reg;
            side7_reg  <= side7_next;
            sq8_reg    <= sq8_next;
            side8_reg  <= side7_reg;
            ps9_reg[0] <= 63'(sq8_reg[0]) + 63'(sq8_reg[1]);
            ps9_reg[1] <= 63'(sq8_reg[2]) + 63'(sq8_reg[3]);
            side9_reg  <= side8_reg;
            tot10_reg  <= 64'(ps9_reg[0]) + 64'(ps9_reg[1]);
            side10_reg <= side9_reg;
        end
    end

    // root of the sum of squares, one bit per cell
    assign rad_w[0]  = tot10_reg;
    assign root_w[0] = 64'd0;

    for (genvar k = 0; k < qs_pkg::SQRT_STEPS; k++) begin : g_root
        qs_sqrt_cell u_cell (
            .aclk     (aclk),
            .adv      (adv),
            .idx      (5'(k)),
            .rad_in   (rad_w[k]),
            .root_in  (root_w[k]),
            .rad_out  (rad_w[k+1]),
            .root_out (root_w[k+1])
        );
    end

    // hold magnitudes beside the root cells
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_side_reg[0] <= side10_reg;
            for (int k = 1; k < qs_pkg::SQRT_STEPS; k++) begin
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    // set up rounded numerators: mag * 2^30 + norm / 2
    always_comb begin
        dvs = root_w[qs_pkg::SQRT_STEPS][31:0];
        for (int i = 0; i < 4; i++) begin
            num[i] = {sq_side_reg[qs_pkg::SQRT_STEPS-1].mag[i], 30'd0} + 61'(dvs >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                remp_reg[i] <= {2'd0, num[i][60:31]};
                quop_reg[i] <= num[i][30:0];
            end
            dvsp_reg  <= dvs;
            sidep_reg <= {sq_side_reg[qs_pkg::SQRT_STEPS-1].sgn,
                          sq_side_reg[qs_pkg::SQRT_STEPS-1].zero};
        end
    end

    // one divider chain per component
    for (genvar i = 0; i < 4; i++) begin : g_lane
        assign rem_w[i][0] = remp_reg[i];
        assign quo_w[i][0] = quop_reg[i];
        assign dvs_w[i][0] = dvsp_reg;
        for (genvar k = 0; k < qs_pkg::DIV_STEPS; k++) begin : g_div
            qs_div_cell u_cell (
                .aclk    (aclk),
                .adv     (adv),
                .rem_in  (rem_w[i][k]),
                .quo_in  (quo_w[i][k]),
                .dvs_in  (dvs_w[i][k]),
                .rem_out (rem_w[i][k+1]),
                .quo_out (quo_w[i][k+1]),
                .dvs_out (dvs_w[i][k+1])
            );
        end
    end

    // hold signs and the zero flag beside the divider cells
    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_side_reg[0] <= sidep_reg;
            for (int k = 1; k < qs_pkg::DIV_STEPS; k++) begin
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end
    end

    // cap, restore sign, replace a zero vector by the identity
    always_comb begin
        out_sgn  = dv_side_reg[qs_pkg::DIV_STEPS-1][4:1];
        out_zero = dv_side_reg[qs_pkg::DIV_STEPS-1][0];
        for (int i = 0; i < 4; i++) begin
            capq[i] = (quo_w[i][qs_pkg::DIV_STEPS] > qs_pkg::ONE_Q30) ?
                      qs_pkg::ONE_Q30 : quo_w[i][qs_pkg::DIV_STEPS];
            unit_next[i] = out_sgn[i] ? (32'd0 - {1'b0, capq[i]}) : {1'b0, capq[i]};
        end
        if (out_zero) begin
            unit_next[0] = 32'd0;
            unit_next[1] = 32'd0;
            unit_next[2] = 32'd0;
            unit_next[3] = {1'b0, qs_pkg::ONE_Q30};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            unit_reg <= unit_next;
        end
    end

    assign unit_out = unit_reg;

endmodule

@@ hdl/quaternion_slerp.sv @@
// Throughput: one word per cycle; the pipeline is a fixed chain of cells
// (root, divider and CORDIC steps), one step per cell per clock.
// A stalled result word holds the whole chain until it is taken.
// Reset (aresetn low, synchronous) clears the valid line only; payload
// registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_slerp
// Spherical linear interpolation of two quaternions in Q30 with a normalized
// linear fallback for nearly equal inputs; the result is a unit quaternion.
// ----------------------------------------------------------------------------
module quaternion_slerp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_a_x,
    input  logic signed [31:0] s_a_y,
    input  logic signed [31:0] s_a_z,
    input  logic signed [31:0] s_a_w,
    input  logic signed [31:0] s_b_x,
    input  logic signed [31:0] s_b_y,
    input  logic signed [31:0] s_b_z,
    input  logic signed [31:0] s_b_w,
    input  logic [16:0]        s_blend,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_q_x,
    output logic signed [31:0] m_q_y,
    output logic signed [31:0] m_q_z,
    output logic signed [31:0] m_q_w
);

    localparam int SQ = qs_pkg::SQRT_STEPS;
    localparam int CS = qs_pkg::CORDIC_STEPS;
    localparam int ML = qs_pkg::MID_LAT;

    logic adv;
    logic [qs_pkg::TOTAL_LAT-1:0] vld_reg;

    logic [3:0][63:0] a_vec, b_vec;
    logic [3:0][31:0] ua, ub;
    logic [16:0]      t_sat;
    logic [16:0]      t_line_reg [0:qs_pkg::NORM_LAT-1];

    // dot product and cosine stages
    logic [3:0][63:0] prod1_reg;
    logic [3:0][31:0] ua1_reg, ub1_reg, ua2_reg, ub2_reg, ua3_reg, ub3_reg;
    logic [3:0][31:0] ua4_reg, ub4_reg, ua5_reg, ub5_reg;
    logic [16:0]      t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [1:0][63:0] ps2_reg;
    logic [63:0]      dot3_reg;
    logic             neg;
    logic [63:0]      dabs;
    logic [63:0]      csh;
    logic [30:0]      c30_4_reg, c30_4_next, c30_5_reg;
    logic [3:0][31:0] ubn;
    logic             lin5_reg;
    logic [61:0]      sq5_reg;
    logic [63:0]      arg6_reg;
    qs_pkg::qs_side_t side6_reg;
    qs_pkg::qs_side_t side_line_reg [0:ML-1];

    // angle math
    logic [63:0]        rad_w  [0:SQ];
    logic [63:0]        root_w [0:SQ];
    logic signed [33:0] vx_w [0:CS];
    logic signed [33:0] vy_w [0:CS];
    logic signed [33:0] vz_w [0:CS];
    logic signed [33:0] ax_w [0:CS];
    logic signed [33:0] ay_w [0:CS];
    logic signed [33:0] az_w [0:CS];
    logic signed [33:0] bx_w [0:CS];
    logic signed [33:0] by_w [0:CS];
    logic signed [33:0] bz_w [0:CS];
    logic [30:0]        theta;
    logic [16:0]        te;
    logic [47:0]        pap1_reg, pbp1_reg;
    logic [47:0]        par, pbr;
    logic [31:0]        pa2_reg, pb2_reg;

    // blend stages
    qs_pkg::qs_side_t   sd;
    logic signed [32:0] sa, sb;
    logic signed [64:0] spa_full [4];
    logic signed [64:0] spb_full [4];
    logic signed [32:0] diff [4];
    logic signed [17:0] t_s;
    logic signed [50:0] lp [4];
    logic [3:0][63:0]   spa1_reg, spb1_reg;
    logic [3:0][50:0]   lp1_reg;
    logic [3:0][31:0]   uaf1_reg;
    logic               linf1_reg;
    logic [3:0][63:0]   r2_reg, r2_next;
    logic [3:0][31:0]   q_unit;

    // the chain moves whenever the output word is free or being taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[qs_pkg::TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[qs_pkg::TOTAL_LAT-2:0], s_valid};
        end
    end

    // normalize both inputs
    assign a_vec = {{{32{s_a_w[31]}}, s_a_w}, {{32{s_a_z[31]}}, s_a_z},
                    {{32{s_a_y[31]}}, s_a_y}, {{32{s_a_x[31]}}, s_a_x}};
    assign b_vec = {{{32{s_b_w[31]}}, s_b_w}, {{32{s_b_z[31]}}, s_b_z},
                    {{32{s_b_y[31]}}, s_b_y}, {{32{s_b_x[31]}}, s_b_x}};

    qs_norm u_norm_a (.aclk(aclk), .adv(adv), .vec_in(a_vec), .unit_out(ua));
    qs_norm u_norm_b (.aclk(aclk), .adv(adv), .vec_in(b_vec), .unit_out(ub));

    // saturate the blend fraction and hold it beside the normalizers
    assign t_sat = (s_blend > qs_pkg::BLEND_ONE) ? qs_pkg::BLEND_ONE : s_blend;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_line_reg[0] <= t_sat;
            for (int k = 1; k < qs_pkg::NORM_LAT; k++) begin
                t_line_reg[k] <= t_line_reg[k-1];
            end
        end
    end

    // short-arc fix and clamped Q30 cosine
    always_comb begin
        neg  = dot3_reg[63];
        dabs = neg ? (64'd0 - dot3_reg) : dot3_reg;
        csh  = dabs >> 30;
        c30_4_next = (csh > 64'(qs_pkg::ONE_Q30)) ? qs_pkg::ONE_Q30 : csh[30:0];
        for (int i = 0; i < 4; i++) begin
            ubn[i] = neg ? (32'd0 - ub3_reg[i]) : ub3_reg[i];
        end
    end

    // dot product, cosine, branch test and 1 - c^2
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                prod1_reg[i] <= 64'($signed(ua[i])) * 64'($signed(ub[i]));
            end
            ua1_reg <= ua;
            ub1_reg <= ub;
            t1_reg  <= t_line_reg[qs_pkg::NORM_LAT-1];

            ps2_reg[0] <= prod1_reg[0] + prod1_reg[1];
            ps2_reg[1] <= prod1_reg[2] + prod1_reg[3];
            ua2_reg <= ua1_reg;
            ub2_reg <= ub1_reg;
            t2_reg  <= t1_reg;

            dot3_reg <= ps2_reg[0] + ps2_reg[1];
            ua3_reg  <= ua2_reg;
            ub3_reg  <= ub2_reg;
            t3_reg   <= t2_reg;

            c30_4_reg <= c30_4_next;
            ua4_reg   <= ua3_reg;
            ub4_reg   <= ubn;
            t4_reg    <= t3_reg;

            lin5_reg  <= (45'(c30_4_reg) * 45'(qs_pkg::COS_SCALE)) > qs_pkg::COS_LIMIT;
            sq5_reg   <= 62'(c30_4_reg) * 62'(c30_4_reg);
            c30_5_reg <= c30_4_reg;
            ua5_reg   <= ua4_reg;
            ub5_reg   <= ub4_reg;
            t5_reg    <= t4_reg;

            arg6_reg      <= (64'd1 << 60) - 64'(sq5_reg);
            side6_reg.ua  <= ua5_reg;
            side6_reg.ub  <= ub5_reg;
            side6_reg.t   <= t5_reg;
            side6_reg.lin <= lin5_reg;
            side6_reg.c30 <= c30_5_reg;
        end
    end

    // hold operands beside the angle cells
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_line_reg[0] <= side6_reg;
            for (int k = 1; k < ML; k++) begin
                side_line_reg[k] <= side_line_reg[k-1];
            end
        end
    end

    // sine of the angle: root of 1 - c^2
    assign rad_w[0]  = arg6_reg;
    assign root_w[0] = 64'd0;

    for (genvar k = 0; k < SQ; k++) begin : g_root
        qs_sqrt_cell u_cell (
            .aclk     (aclk),
            .adv      (adv),
            .idx      (5'(k)),
            .rad_in   (rad_w[k]),
            .root_in  (root_w[k]),
            .rad_out  (rad_w[k+1]),
            .root_out (root_w[k+1])
        );
    end

    // angle from (cos, sin) by vectoring
    assign vx_w[0] = $signed({3'd0, side_line_reg[SQ-1].c30});
    assign vy_w[0] = $signed(root_w[SQ][33:0]);
    assign vz_w[0] = 34'sd0;

    for (genvar k = 0; k < CS; k++) begin : g_vec
        qs_cordic_cell u_cell (
            .aclk  (aclk),
            .adv   (adv),
            .mode  (qs_pkg::CORDIC_VECTOR),
            .idx   (5'(k)),
            .x_in  (vx_w[k]),
            .y_in  (vy_w[k]),
            .z_in  (vz_w[k]),
            .x_out (vx_w[k+1]),
            .y_out (vy_w[k+1]),
            .z_out (vz_w[k+1])
        );
    end

    // split the angle by the blend fraction, rounded
    assign theta = vz_w[CS][33] ? 31'd0 : vz_w[CS][30:0];
    assign te    = side_line_reg[SQ+CS-1].t;
    assign par   = pap1_reg + 48'd32768;
    assign pbr   = pbp1_reg + 48'd32768;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pbp1_reg <= 48'(theta) * 48'(te);
            pap1_reg <= 48'(theta) * 48'(qs_pkg::BLEND_ONE - te);
            pa2_reg  <= par[47:16];
            pb2_reg  <= pbr[47:16];
        end
    end

    // sines of both partial angles by rotation
    assign ax_w[0] = qs_pkg::CORDIC_GAIN;
    assign ay_w[0] = 34'sd0;
    assign az_w[0] = $signed({2'd0, pa2_reg});
    assign bx_w[0] = qs_pkg::CORDIC_GAIN;
    assign by_w[0] = 34'sd0;
    assign bz_w[0] = $signed({2'd0, pb2_reg});

    for (genvar k = 0; k < CS; k++) begin : g_rot
        qs_cordic_cell u_cell_a (
            .aclk  (aclk),
            .adv   (adv),
            .mode  (qs_pkg::CORDIC_ROTATE),
            .idx   (5'(k)),
            .x_in  (ax_w[k]),
            .y_in  (ay_w[k]),
            .z_in  (az_w[k]),
            .x_out (ax_w[k+1]),
            .y_out (ay_w[k+1]),
            .z_out (az_w[k+1])
        );
        qs_cordic_cell u_cell_b (
            .aclk  (aclk),
            .adv   (adv),
            .mode  (qs_pkg::CORDIC_ROTATE),
            .idx   (5'(k)),
            .x_in  (bx_w[k]),
            .y_in  (by_w[k]),
            .z_in  (bz_w[k]),
            .x_out (bx_w[k+1]),
            .y_out (by_w[k+1]),
            .z_out (bz_w[k+1])
        );
    end

    // weighted sums for both paths
    always_comb begin
        sd  = side_line_reg[ML-1];
        sa  = ay_w[CS][32:0];
        sb  = by_w[CS][32:0];
        t_s = $signed({1'b0, sd.t});
        for (int i = 0; i < 4; i++) begin
            spa_full[i] = 65'(sa) * 65'($signed(sd.ua[i]));
            spb_full[i] = 65'(sb) * 65'($signed(sd.ub[i]));
            diff[i]     = 33'($signed(sd.ub[i])) - 33'($signed(sd.ua[i]));
            lp[i]       = 51'(diff[i]) * 51'(t_s);
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (linf1_reg) begin
                r2_next[i] = (64'($signed(uaf1_reg[i])) <<< 16) + 64'($signed(lp1_reg[i]));
            end else begin
                r2_next[i] = spa1_reg[i] + spb1_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                spa1_reg[i] <= spa_full[i][63:0];
                spb1_reg[i] <= spb_full[i][63:0];
                lp1_reg[i]  <= lp[i];
            end
            uaf1_reg  <= sd.ua;
            linf1_reg <= sd.lin;
            r2_reg    <= r2_next;
        end
    end

    // final normalization drives the result word
    qs_norm u_norm_r (.aclk(aclk), .adv(adv), .vec_in(r2_reg), .unit_out(q_unit));

    assign m_q_x = $signed(q_unit[0]);
    assign m_q_y = $signed(q_unit[1]);
    assign m_q_z = $signed(q_unit[2]);
    assign m_q_w = $signed(q_unit[3]);

    // result components stay within one
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_q_x >= -32'sd1073741824) && (m_q_x <= 32'sd1073741824) &&
                    (m_q_y >= -32'sd1073741824) && (m_q_y <= 32'sd1073741824) &&
                    (m_q_z >= -32'sd1073741824) && (m_q_z <= 32'sd1073741824) &&
                    (m_q_w >= -32'sd1073741824) && (m_q_w <= 32'sd1073741824))
        else $error("result component out of unit range");

    // a unit quaternion is never the zero vector
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !((m_q_x == 32'sd0) && (m_q_y == 32'sd0) &&
                      (m_q_z == 32'sd0) && (m_q_w == 32'sd0)))
        else $error("result word is the zero quaternion");

    // a pure scalar result must be plus or minus one
    a_scalar_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_q_x == 32'sd0) && (m_q_y == 32'sd0) && (m_q_z == 32'sd0)) |->
            ((m_q_w == 32'sd1073741824) || (m_q_w == -32'sd1073741824)))
        else $error("scalar result is not of unit length");

endmodule
